// ----- hw/rtl/tnke_pkg.sv -----
// ----------------------------------------------------------------------------
// tnke_pkg
// Telnet codes, register indexes and the key encoding function for the
// NVT key encoder.
// ----------------------------------------------------------------------------
package tnke_pkg;

    localparam logic [7:0] TN_IAC     = 8'd255;
    localparam logic [7:0] TN_IP      = 8'd244;
    localparam logic [7:0] TN_AO      = 8'd245;
    localparam logic [7:0] TN_EC      = 8'd247;
    localparam logic [7:0] TN_EL      = 8'd248;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] ASCII_MASK = 8'h7f;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BINARY_SEND    = 3'd0,
        REG_CRLF_IN_BINARY = 3'd1,
        REG_INTERRUPT_CHAR = 3'd2,
        REG_QUIT_CHAR      = 3'd3,
        REG_ERASE_CHAR     = 3'd4,
        REG_KILL_CHAR      = 3'd5,
        REG_FLUSH_CHAR     = 3'd6,
        REG_UNUSED         = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic       binary_send;
        logic       crlf_in_binary;
        logic [6:0] interrupt_char;
        logic [6:0] quit_char;
        logic [6:0] erase_char;
        logic [6:0] kill_char;
        logic [6:0] flush_char;
    } cfg_t;

    // Encoded key: one or two bytes; byte1 is meaningful only when two is set.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
    } enc_t;

    function automatic enc_t encode_key(input logic [7:0] key, input cfg_t cfg);
        enc_t       e;
        logic [6:0] c;
        c       = key[6:0];
        e.byte0 = key;
        e.byte1 = CH_LF;
        e.two   = 1'b0;
        if (cfg.binary_send) begin
            if (key == TN_IAC) begin
                e.byte1 = TN_IAC;
                e.two   = 1'b1;
            end else if (key == CH_LF && cfg.crlf_in_binary) begin
                e.byte0 = CH_CR;
                e.two   = 1'b1;
            end
        end else begin
            // first match wins
            e.byte0 = TN_IAC;
            e.two   = 1'b1;
            if (c == cfg.interrupt_char || c == cfg.quit_char) begin
                e.byte1 = TN_IP;
            end else if (c == cfg.erase_char) begin
                e.byte1 = TN_EC;
            end else if (c == cfg.kill_char) begin
                e.byte1 = TN_EL;
            end else if (c == cfg.flush_char) begin
                e.byte1 = TN_AO;
            end else if (c == CH_LF[6:0]) begin
                e.byte0 = CH_CR;
            end else begin
                e.byte0 = key & ASCII_MASK;
                e.two   = 1'b0;
            end
        end
        return e;
    endfunction

endpackage

// ----- hw/rtl/telnet_nvt_key_encoder_top.sv -----
// ----------------------------------------------------------------------------
// telnet_nvt_key_encoder_top
// Keyboard byte to Telnet byte stream encoder (binary and NVT modes).
// A key accepted on s_ passes the pending stage and the output register to m_.
// One byte per cycle out while m_tready is high; unstalled, a one-byte key can
// enter every cycle; after a two-byte key, s_ waits until both bytes move out.
// Reset (aresetn, synchronous, active low) empties both stages and loads
// the register defaults: NVT mode, ^C / ^\ / DEL / ^U / ^O.
// ----------------------------------------------------------------------------
module telnet_nvt_key_encoder_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [tnke_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tnke_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // key input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] key_byte
    // byte output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] out_byte
    output logic                                m_tlast    // last byte of key
);
    import tnke_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // pending stage: encoded key waiting to be split into words
    enc_t pend_reg;
    logic pend_valid_reg;
    logic pend_phase_reg;     // 1 once the first byte of a pair has moved out

    // output register
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_valid_reg;

    logic       out_load;     // output register takes a word this cycle
    logic       pend_move;    // pending stage hands a word to the output
    logic       pend_done;    // that word is the key's last
    logic       s_accept;
    enc_t       enc_next;

    assign out_load  = !out_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_load;
    assign pend_done = pend_move && (pend_phase_reg || !pend_reg.two);
    // a new key can enter while the previous one is leaving
    assign s_tready  = !pend_valid_reg || pend_done;
    assign s_accept  = s_tvalid && s_tready;
    assign enc_next  = encode_key(s_tdata, cfg_reg);

    // config writes; unused index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.binary_send    <= 1'b0;
            cfg_reg.crlf_in_binary <= 1'b0;
            cfg_reg.interrupt_char <= 7'd3;
            cfg_reg.quit_char      <= 7'd28;
            cfg_reg.erase_char     <= 7'd127;
            cfg_reg.kill_char      <= 7'd21;
            cfg_reg.flush_char     <= 7'd15;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_BINARY_SEND:    cfg_reg.binary_send    <= cfg_wdata[0];
                REG_CRLF_IN_BINARY: cfg_reg.crlf_in_binary <= cfg_wdata[0];
                REG_INTERRUPT_CHAR: cfg_reg.interrupt_char <= cfg_wdata;
                REG_QUIT_CHAR:      cfg_reg.quit_char      <= cfg_wdata;
                REG_ERASE_CHAR:     cfg_reg.erase_char     <= cfg_wdata;
                REG_KILL_CHAR:      cfg_reg.kill_char      <= cfg_wdata;
                REG_FLUSH_CHAR:     cfg_reg.flush_char     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pending stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_phase_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                pend_valid_reg <= 1'b1;
                pend_phase_reg <= 1'b0;
            end else if (pend_done) begin
                pend_valid_reg <= 1'b0;
                pend_phase_reg <= 1'b0;
            end else if (pend_move) begin
                pend_phase_reg <= 1'b1;
            end
        end
    end

    // pending payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_reg <= enc_next;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= pend_valid_reg;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (pend_move) begin
            out_byte_reg <= pend_phase_reg ? pend_reg.byte1 : pend_reg.byte0;
            out_last_reg <= pend_phase_reg || !pend_reg.two;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule
